// ===== sv/cbd_pkg.sv =====
// shared types, constants and character helpers for the chunked body decoder
// no dependencies
package cbd_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_VT = 8'h0b;
    localparam logic [7:0] CHAR_FF = 8'h0c;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_X_LO = 8'h78;
    localparam logic [7:0] CHAR_X_UP = 8'h58;

    localparam logic [1:0] ST_TERMINATED = 2'd0;
    localparam logic [1:0] ST_EARLY_END = 2'd1;
    localparam logic [1:0] ST_NEGATIVE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       has_end;
        logic [1:0] status;
    } cbd_entry_t;

    // bit 4 marks a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT
            || c == CHAR_FF || c == CHAR_CR;
    endfunction

endpackage

// ===== sv/cbd_front.sv =====
// front end: accepts raw body beats, parses chunk size lines, classifies beats
// depends on cbd_pkg
module cbd_front #(
    parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output logic               push,
    output cbd_pkg::cbd_entry_t entry
);
    import cbd_pkg::*;

    localparam logic [1:0] PH_SIZE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;
    localparam logic [1:0] PH_END = 2'd3;

    localparam logic [2:0] HS_BLANKS = 3'd0;
    localparam logic [2:0] HS_SIGN = 3'd1;
    localparam logic [2:0] HS_ZERO = 3'd2;
    localparam logic [2:0] HS_AFTERX = 3'd3;
    localparam logic [2:0] HS_DIGITS = 3'd4;
    localparam logic [2:0] HS_DONE = 3'd5;

    logic [1:0]           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] acc_reg, acc_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic [2:0]           hs_reg, hs_next;
    logic                 pcr_reg, pcr_next;
    logic                 ovf_reg, ovf_next;
    logic                 neg_reg, neg_next;
    logic [1:0]           skip_reg, skip_next;

    logic [4:0] hex;
    logic       sign_path;
    logic       nonzero;
    logic       ended;

    assign hex = hex_digit(in_byte);
    assign nonzero = (acc_reg != '0) || ovf_reg;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        hs_next = hs_reg;
        pcr_next = pcr_reg;
        ovf_next = ovf_reg;
        neg_next = neg_reg;
        skip_next = skip_reg;
        entry = '0;
        sign_path = 1'b0;
        ended = 1'b0;
        if (accept && phase_reg != PH_END)
        begin
            unique case (phase_reg)
                PH_SIZE:
                begin
                    if (in_byte == CHAR_LF && pcr_reg)
                    begin
                        if (neg_reg && nonzero)
                        begin
                            ended = 1'b1;
                            entry.status = ST_NEGATIVE;
                        end
                        else if (ovf_reg)
                        begin
                            ended = 1'b1;
                            entry.status = ST_OVERFLOW;
                        end
                        else if (!nonzero)
                        begin
                            ended = 1'b1;
                            entry.status = ST_TERMINATED;
                        end
                        else
                        begin
                            rem_next = acc_reg;
                            phase_next = PH_DATA;
                        end
                    end
                    else
                    begin
                        pcr_next = (in_byte == CHAR_CR);
                        if (hs_reg == HS_BLANKS)
                        begin
                            if (!is_blank(in_byte))
                            begin
                                if (in_byte == CHAR_PLUS || in_byte == CHAR_MINUS)
                                begin
                                    neg_next = (in_byte == CHAR_MINUS);
                                    hs_next = HS_SIGN;
                                end
                                else
                                begin
                                    sign_path = 1'b1;
                                end
                            end
                        end
                        else if (hs_reg == HS_SIGN)
                        begin
                            sign_path = 1'b1;
                        end
                        else if (hs_reg == HS_ZERO && (in_byte == CHAR_X_LO
                                 || in_byte == CHAR_X_UP))
                        begin
                            hs_next = HS_AFTERX;
                        end
                        else if (hs_reg != HS_DONE)
                        begin
                            if (hex[4])
                            begin
                                hs_next = HS_DIGITS;
                                if (acc_reg[SIZE_BITS-1 -: 4] != 4'd0)
                                    ovf_next = 1'b1;
                                else
                                    acc_next = {acc_reg[SIZE_BITS-5:0], hex[3:0]};
                            end
                            else
                            begin
                                hs_next = HS_DONE;
                            end
                        end
                        if (sign_path)
                        begin
                            if (in_byte == CHAR_ZERO)
                            begin
                                hs_next = HS_ZERO;
                            end
                            else if (hex[4])
                            begin
                                hs_next = HS_DIGITS;
                                if (acc_reg[SIZE_BITS-1 -: 4] != 4'd0)
                                    ovf_next = 1'b1;
                                else
                                    acc_next = {acc_reg[SIZE_BITS-5:0], hex[3:0]};
                            end
                            else
                            begin
                                hs_next = HS_DONE;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    entry.has_data = 1'b1;
                    entry.data_byte = in_byte;
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == SIZE_BITS'(1))
                    begin
                        phase_next = PH_SKIP;
                        skip_next = 2'd2;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 2'd1;
                    if (skip_reg == 2'd1)
                    begin
                        phase_next = PH_SIZE;
                        acc_next = '0;
                        hs_next = HS_BLANKS;
                        pcr_next = 1'b0;
                        ovf_next = 1'b0;
                        neg_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            if (!ended && in_last)
            begin
                ended = 1'b1;
                entry.status = ST_EARLY_END;
            end
            if (ended)
            begin
                entry.has_end = 1'b1;
                phase_next = PH_END;
            end
        end
    end

    assign push = entry.has_data || entry.has_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            acc_reg <= '0;
            rem_reg <= '0;
            hs_reg <= HS_BLANKS;
            pcr_reg <= 1'b0;
            ovf_reg <= 1'b0;
            neg_reg <= 1'b0;
            skip_reg <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            hs_reg <= hs_next;
            pcr_reg <= pcr_next;
            ovf_reg <= ovf_next;
            neg_reg <= neg_next;
            skip_reg <= skip_next;
        end
    end

endmodule

// ===== sv/cbd_queue.sv =====
// short queue of classified beats between front and back end
// depends on cbd_pkg
module cbd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cbd_pkg::cbd_entry_t push_entry,
    input  logic                pop,
    output cbd_pkg::cbd_entry_t head,
    output logic                full,
    output logic                empty
);
    import cbd_pkg::*;

    cbd_entry_t            slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;

    assign full = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== sv/cbd_back.sv =====
// back end: turns queued entries into output beats through an output register
// depends on cbd_pkg
module cbd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cbd_pkg::cbd_entry_t head,
    input  logic                empty,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);
    import cbd_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       is_data_reg;
    logic       is_end_reg;
    logic [1:0] status_reg;
    logic       pend_reg;
    logic [1:0] pend_status_reg;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;
    assign pop = out_free && !pend_reg && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg <= 1'b0;
            end
            else if (!empty)
            begin
                valid_reg <= 1'b1;
                pend_reg <= head.has_data && head.has_end;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_reg)
            begin
                data_reg <= 8'd0;
                is_data_reg <= 1'b0;
                is_end_reg <= 1'b1;
                status_reg <= pend_status_reg;
            end
            else if (!empty)
            begin
                pend_status_reg <= head.status;
                if (head.has_data)
                begin
                    data_reg <= head.data_byte;
                    is_data_reg <= 1'b1;
                    is_end_reg <= 1'b0;
                    status_reg <= ST_TERMINATED;
                end
                else
                begin
                    data_reg <= 8'd0;
                    is_data_reg <= 1'b0;
                    is_end_reg <= 1'b1;
                    status_reg <= head.status;
                end
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = data_reg;
    assign m_tuser = {status_reg, is_data_reg};
    assign m_tlast = is_end_reg;

endmodule

// ===== sv/chunked_body_decoder_core.sv =====
// top level of the chunked body decoder: front parser, beat queue, output back end
// depends on cbd_pkg, cbd_front, cbd_queue, cbd_back
// path: a payload beat is registered in a queue slot, then in the output register
// throughput: one input beat per cycle while the queue is not full; a beat that
// yields both a payload and an end result is sent as two output beats, absorbed by the four-entry queue
// reset: asynchronous, clears parser state, queue pointers and output valid
// after the end result every further input beat is accepted and dropped
module chunked_body_decoder_core #(
    parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [2:0] m_tuser,   // {end_status[1:0], is_data}
    output logic       m_tlast    // is_end
);
    import cbd_pkg::*;

    logic       accept;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    cbd_entry_t push_entry;
    cbd_entry_t head;

    assign s_tready = !q_full;
    assign accept = s_tvalid && s_tready;

    cbd_front #(
        .SIZE_BITS(SIZE_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .in_byte(s_tdata),
        .in_last(s_tlast),
        .push(push),
        .entry(push_entry)
    );

    cbd_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_entry(push_entry),
        .pop(pop),
        .head(head),
        .full(q_full),
        .empty(q_empty)
    );

    cbd_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head(head),
        .empty(q_empty),
        .pop(pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("queue overrun");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_empty || m_tvalid)
        else $error("pushed entry lost");

    a_end_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid && q_empty)
        else $error("beat after end of body");

endmodule
